// ===== hw/rtl/rls_pkg.sv =====
package rls_pkg;

	// Default sizes of the send-time table and the histogram.
	localparam int SeqEntriesDef = 1024;
	localparam int HistBinsDef   = 1024;

	// Register reset value and queue depth.
	localparam logic [15:0] BinWidthRst = 16'd1000;
	localparam int          QDepth      = 2;

	// Width of the shared divider's dividend and quotient.
	localparam int DivW = 41;

	// Saturation limits of the mean and deviation accumulators.
	localparam logic signed [41:0] Max40S = 42'sh0_7F_FFFF_FFFF;
	localparam logic signed [41:0] Min40S = -42'sh0_80_0000_0000;
	localparam logic [38:0]        Max39  = 39'h7F_FFFF_FFFF;

	// Event codes carried in the mode field.
	localparam logic [1:0] ModeSend = 2'd0;
	localparam logic [1:0] ModeRecv = 2'd1;
	localparam logic [1:0] ModeRead = 2'd2;

	typedef enum logic [1:0] {
		OP_SEND,
		OP_RECV,
		OP_READ,
		OP_NONE
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SLOT1,
		ST_SLOT2,
		ST_SEND,
		ST_SRD,
		ST_RTT,
		ST_BDIV,
		ST_HRD,
		ST_HUPD,
		ST_MDIV,
		ST_MEAN,
		ST_DDIV,
		ST_READ,
		ST_RDAT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] seq_no;
		logic [31:0] time_us;
		logic [9:0]  bin_index;
	} req_t;

	typedef struct packed {
		logic signed [31:0] rtt_us;
		logic [9:0]         rtt_bin;
		logic signed [31:0] min_rtt_us;
		logic signed [31:0] max_rtt_us;
		logic signed [39:0] mean_rtt;
		logic [38:0]        mean_deviation;
		logic [31:0]        received_count;
		logic [31:0]        sent_count;
		logic [31:0]        bin_count;
	} rsp_t;

	// Classified event as it waits in the queue.
	typedef struct packed {
		op_t         op;
		logic [15:0] seq_no;
		logic [31:0] time_us;
		logic [9:0]  bin_index;
		logic        rd_ok;
	} cmd_t;

	typedef struct packed {
		logic            start;
		logic [DivW-1:0] dividend;
		logic [31:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DivW-1:0] quot;
	} div_rsp_t;

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

// ===== hw/rtl/rtt_latency_statistics.sv =====
// Round-trip latency statistics.
// Input channel req_valid/req_ready/req carries one event item: a send stores
// time_us under seq_no, a receive forms the round-trip time and updates the
// histogram, minimum, maximum, mean and mean deviation, a read returns one bin.
// Every item yields one result item on rsp_valid/rsp_ready/rsp.
// cfg_we/cfg_data write the bin width; write it only while the block is idle.
// The sequencer executes one item at a time. A receive uses the shared
// restoring divider, one quotient bit a cycle over 41 bits: for the bin, only
// when the round-trip time is positive, then for the mean and the deviation.
// A two-entry queue sits between the front and the execution sequencer, so
// items are still taken while one executes or a result waits.
// After reset the histogram is cleared, one bin a cycle over all HIST_BINS
// bins; req_ready stays low until that pass ends.
// When the receiver stalls, the result holds in its register, the sequencer
// waits after finishing the next item, and the queue fills, then req_ready drops.
module rtt_latency_statistics import rls_pkg::*; #(
	parameter int SEQ_ENTRIES = SeqEntriesDef,
	parameter int HIST_BINS   = HistBinsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);

	logic clear_done;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// Front: classify events and queue them.
	rls_front #(
		.HIST_BINS (HIST_BINS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.clear_done (clear_done),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	// Back: execute events against the tables and statistics.
	rls_back #(
		.SEQ_ENTRIES (SEQ_ENTRIES),
		.HIST_BINS   (HIST_BINS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.clear_done (clear_done),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

// ===== hw/rtl/rls_front.sv =====
module rls_front import rls_pkg::*; #(
	parameter int HIST_BINS = HistBinsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	input  logic clear_done,
	output logic cmd_valid,
	input  logic cmd_ready,
	output cmd_t cmd
);

	cmd_t       fifo_q [QDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	// Decode the event and check the read index against the histogram size.
	always_comb begin
		case (req.mode)
			ModeSend: cls.op = OP_SEND;
			ModeRecv: cls.op = OP_RECV;
			ModeRead: cls.op = OP_READ;
			default:  cls.op = OP_NONE;
		endcase
		cls.seq_no    = req.seq_no;
		cls.time_us   = req.time_us;
		cls.bin_index = req.bin_index;
		cls.rd_ok     = 32'(req.bin_index) < 32'(HIST_BINS);
	end

	// Items are taken only once the histogram has been cleared.
	assign req_ready = clear_done && (cnt_q != 2'(QDepth));
	assign push      = req_valid && req_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/rls_div.sv =====
module rls_div import rls_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t dreq,
	output div_rsp_t drsp
);

	localparam int CntW = $clog2(DivW + 1);

	logic [DivW-1:0] dvd_q;
	logic [31:0]     dsr_q;
	logic [31:0]     rem_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [32:0]     trial;
	logic            fits;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, dvd_q[DivW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (dreq.start) begin
			dvd_q <= dreq.dividend;
			dsr_q <= dreq.divisor;
			rem_q <= 32'd0;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
			dvd_q <= {dvd_q[DivW-2:0], fits};
		end
	end

	// Step counter; done pulses once the last quotient bit is in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign drsp.done = done_q;
	assign drsp.quot = dvd_q;

endmodule

// ===== hw/rtl/rls_back.sv =====
module rls_back import rls_pkg::*; #(
	parameter int SEQ_ENTRIES = SeqEntriesDef,
	parameter int HIST_BINS   = HistBinsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        clear_done,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp
);

	localparam int SeqW = $clog2(SEQ_ENTRIES);
	localparam int HbW  = $clog2(HIST_BINS);
	localparam logic [32:0] SeqRecip = 33'((64'd1 << 32) / 64'(SEQ_ENTRIES) + 64'd1);

	state_t state_q, state_d;

	// Memories.
	logic [31:0] send_mem [SEQ_ENTRIES];
	logic [31:0] hist_mem [HIST_BINS];
	logic [31:0] sd_rd_q;
	logic [31:0] hist_rd_q;

	logic            hist_we;
	logic [HbW-1:0]  hist_waddr;
	logic [31:0]     hist_wdata;
	logic [HbW-1:0]  hist_raddr;
	logic            send_we;

	// Item and working registers.
	cmd_t               cmd_q;
	logic [15:0]        idx_q;
	logic [SeqW-1:0]    slot_q;
	logic signed [31:0] rtt_q;
	logic [HbW-1:0]     bin_q;
	logic [31:0]        bcount_q;
	logic               neg_q;
	logic [HbW-1:0]     clr_q;

	// Statistics and configuration.
	logic [15:0]        bin_width_q;
	logic [31:0]        rx_q;
	logic [31:0]        tx_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic signed [39:0] mean_q;
	logic [38:0]        dev_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	div_req_t dreq;
	div_rsp_t drsp;

	// Combinational datapath.
	logic [15:0]        width_eff;
	logic signed [31:0] rtt_c;
	logic [32:0]        prod_c;
	logic [16:0]        rem_c;
	logic [16:0]        rem_fix;
	logic [31:0]        hinc;
	logic [31:0]        rx_inc;
	logic signed [39:0] x_c;
	logic signed [40:0] mdiff;
	logic [40:0]        mmag;
	logic signed [41:0] qs;
	logic signed [41:0] msum;
	logic signed [39:0] mean_new;
	logic [40:0]        dabs;
	logic [38:0]        d39;
	logic signed [39:0] ddiff;
	logic [39:0]        dmag;
	logic signed [41:0] dsum;
	logic [38:0]        dev_new;
	logic               rsp_load;
	logic [31:0]        bidx32;

	rls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (dreq),
		.drsp   (drsp)
	);

	assign width_eff = (bin_width_q == 16'd0) ? 16'd1 : bin_width_q;
	assign rtt_c     = $signed(cmd_q.time_us - sd_rd_q);
	assign hinc      = sat_inc32(hist_rd_q);
	assign rx_inc    = sat_inc32(rx_q);
	assign x_c       = $signed({rtt_q, 8'd0});
	assign bidx32    = 32'(cmd_q.bin_index);

	// Slot remainder from the registered reciprocal quotient.
	assign prod_c  = 33'(idx_q) * 33'(SEQ_ENTRIES);
	assign rem_c   = {1'b0, cmd_q.seq_no} - prod_c[16:0];
	assign rem_fix = (rem_c >= 17'(SEQ_ENTRIES)) ? rem_c - 17'(SEQ_ENTRIES) : rem_c;

	// Mean step: difference of the scaled sample and the mean, and its update.
	assign mdiff = $signed({x_c[39], x_c}) - $signed({mean_q[39], mean_q});
	assign mmag  = mdiff[40] ? 41'(-mdiff) : 41'(mdiff);
	assign qs    = neg_q ? -$signed({1'b0, drsp.quot}) : $signed({1'b0, drsp.quot});
	assign msum  = $signed({{2{mean_q[39]}}, mean_q}) + qs;
	always_comb begin
		if (msum > Max40S) begin
			mean_new = Max40S[39:0];
		end else if (msum < Min40S) begin
			mean_new = Min40S[39:0];
		end else begin
			mean_new = msum[39:0];
		end
	end

	// Deviation step, using the mean already updated.
	assign dabs  = mdiff[40] ? 41'(-mdiff) : 41'(mdiff);
	assign d39   = (dabs > 41'(Max39)) ? Max39 : dabs[38:0];
	assign ddiff = $signed({1'b0, d39}) - $signed({1'b0, dev_q});
	assign dmag  = ddiff[39] ? 40'(-ddiff) : 40'(ddiff);
	assign dsum  = $signed({3'b000, dev_q}) + qs;
	always_comb begin
		if (dsum < 42'sd0) begin
			dev_new = 39'd0;
		end else if (dsum > $signed({3'b000, Max39})) begin
			dev_new = Max39;
		end else begin
			dev_new = dsum[38:0];
		end
	end

	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory controls and divider requests.
	always_comb begin
		state_d       = state_q;
		cmd_ready     = 1'b0;
		hist_we       = 1'b0;
		hist_waddr    = bin_q;
		hist_wdata    = hinc;
		hist_raddr    = bin_q;
		send_we       = 1'b0;
		dreq.start    = 1'b0;
		dreq.dividend = {{(DivW - 32){1'b0}}, rtt_c};
		dreq.divisor  = {16'd0, width_eff};
		case (state_q)
			ST_CLEAR: begin
				hist_we    = 1'b1;
				hist_waddr = clr_q;
				hist_wdata = 32'd0;
				if (32'(clr_q) == 32'(HIST_BINS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = ST_SLOT1;
				end
			end
			ST_SLOT1: state_d = ST_SLOT2;
			ST_SLOT2: begin
				case (cmd_q.op)
					OP_SEND: state_d = ST_SEND;
					OP_RECV: state_d = ST_SRD;
					OP_READ: state_d = ST_READ;
					default: state_d = ST_DONE;
				endcase
			end
			ST_SEND: begin
				send_we = 1'b1;
				state_d = ST_DONE;
			end
			ST_SRD: state_d = ST_RTT;
			ST_RTT: begin
				if (rtt_c > 32'sd0) begin
					dreq.start = 1'b1;
					state_d    = ST_BDIV;
				end else begin
					state_d = ST_HRD;
				end
			end
			ST_BDIV: begin
				if (drsp.done) begin
					state_d = ST_HRD;
				end
			end
			ST_HRD: state_d = ST_HUPD;
			ST_HUPD: begin
				hist_we       = 1'b1;
				dreq.start    = 1'b1;
				dreq.dividend = mmag;
				dreq.divisor  = rx_inc;
				state_d       = ST_MDIV;
			end
			ST_MDIV: begin
				if (drsp.done) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				dreq.start    = 1'b1;
				dreq.dividend = {1'b0, dmag};
				dreq.divisor  = rx_q;
				state_d       = ST_DDIV;
			end
			ST_DDIV: begin
				if (drsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				hist_raddr = bidx32[HbW-1:0];
				state_d    = ST_RDAT;
			end
			ST_RDAT: state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Send-time table: written on a send, read at the item's slot.
	always_ff @(posedge clk) begin
		if (send_we) begin
			send_mem[slot_q] <= cmd_q.time_us;
		end
		sd_rd_q <= send_mem[slot_q];
	end

	// Histogram memory with registered read.
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rd_q <= hist_mem[hist_raddr];
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q    <= cmd;
				bcount_q <= 32'd0;
				rtt_q    <= 32'sd0;
				bin_q    <= '0;
			end
			ST_SLOT1: idx_q <= 16'((49'(cmd_q.seq_no) * 49'(SeqRecip)) >> 32);
			ST_SLOT2: slot_q <= rem_fix[SeqW-1:0];
			ST_RTT:   rtt_q <= rtt_c;
			ST_BDIV: begin
				if (drsp.done) begin
					bin_q <= (drsp.quot >= DivW'(HIST_BINS)) ? HbW'(HIST_BINS - 1)
						: drsp.quot[HbW-1:0];
				end
			end
			ST_HUPD: begin
				bcount_q <= hinc;
				neg_q    <= mdiff[40];
			end
			ST_MEAN: neg_q <= ddiff[39];
			ST_RDAT: bcount_q <= cmd_q.rd_ok ? hist_rd_q : 32'd0;
			default: ;
		endcase
	end

	// Statistics, configuration and clear sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= BinWidthRst;
			rx_q        <= 32'd0;
			tx_q        <= 32'd0;
			min_q       <= 32'sh7FFF_FFFF;
			max_q       <= 32'sd0;
			mean_q      <= 40'sd0;
			dev_q       <= 39'd0;
			clr_q       <= '0;
		end else begin
			if (cfg_we) begin
				bin_width_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_SEND) begin
				tx_q <= sat_inc32(tx_q);
			end
			if (state_q == ST_HUPD) begin
				rx_q <= rx_inc;
				if (rtt_q < min_q) begin
					min_q <= rtt_q;
				end
				if (rtt_q > max_q) begin
					max_q <= rtt_q;
				end
			end
			if (state_q == ST_MDIV && drsp.done) begin
				mean_q <= mean_new;
			end
			if (state_q == ST_DDIV && drsp.done) begin
				dev_q <= dev_new;
			end
		end
	end

	// Result register: holds a finished item until the receiver takes it.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.rtt_us         <= rtt_q;
			rsp_q.rtt_bin        <= 10'(bin_q);
			rsp_q.min_rtt_us     <= min_q;
			rsp_q.max_rtt_us     <= max_q;
			rsp_q.mean_rtt       <= mean_q;
			rsp_q.mean_deviation <= dev_q;
			rsp_q.received_count <= rx_q;
			rsp_q.sent_count     <= tx_q;
			rsp_q.bin_count      <= bcount_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign clear_done = (state_q != ST_CLEAR);

endmodule

// ===== hw/rtl/rls_checker.sv =====
module rls_checker import rls_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A result that is not taken stays and holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Once a receive has been seen, the minimum cannot exceed the maximum.
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.received_count != 32'd0) |-> rsp.min_rtt_us <= rsp.max_rtt_us)
		else $error("minimum above maximum");

	// Before any receive, the mean, deviation and maximum are still at reset.
	a_no_rx: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.received_count == 32'd0) |->
		(rsp.mean_rtt == 40'sd0) && (rsp.mean_deviation == 39'd0) && (rsp.max_rtt_us == 32'sd0))
		else $error("statistics moved without a receive");

	// Only a positive round-trip time lands past bin zero.
	a_bin_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.rtt_bin != 10'd0) |-> rsp.rtt_us > 32'sd0)
		else $error("nonzero bin for a non-positive time");

endmodule

bind rtt_latency_statistics rls_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
